// File: sv/khbs_pkg.sv
// khbs_pkg: shared types, constants and helpers for the key hash bucket select block
// no dependencies; imported by the channel interfaces and the core
package khbs_pkg;

    localparam int KEY_W    = 8;
    localparam int HASH_W   = 15;
    localparam int BUCKET_W = 16;
    localparam int CRC_W    = 32;
    localparam int CNT_W    = 4;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // last step of the bitwise crc loop and of the remainder loop
    localparam logic [CNT_W-1:0] CRC_LAST_STEP = CNT_W'(KEY_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(HASH_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_DIV,
        ST_DONE
    } t_state;

    // invert the crc, take bits 30..16, and map a zero hash to one
    function automatic logic [HASH_W-1:0] hash_fold(input logic [CRC_W-1:0] crc);
        logic [HASH_W-1:0] h;
        h = ~crc[30:16];
        if (h == '0) begin
            h = HASH_W'(1);
        end
        return h;
    endfunction

endpackage

// File: sv/khbs_if.sv
// khbs_if: valid/ready channel interfaces for key bytes and hash results
// depends on khbs_pkg for field widths
interface khbs_in_if import khbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key_byte;
    logic              last;

    modport source (output valid, key_byte, last, input ready);
    modport sink   (input valid, key_byte, last, output ready);
endinterface

interface khbs_out_if import khbs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HASH_W-1:0]    hash_value;
    logic [BUCKET_W-1:0]  bucket_index;

    modport source (output valid, hash_value, bucket_index, input ready);
    modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface

// File: sv/key_hash_bucket_select_core.sv
// key_hash_bucket_select_core: crc-32 key hash with modulo bucket selection
// depends on khbs_pkg and the khbs_in_if / khbs_out_if channel interfaces

// Key bytes enter one beat at a time and are folded bit by bit into a
// reflected CRC-32 (poly 0xEDB88320, init all ones) by one shift/xor unit:
// a byte that is not last is accepted and then takes 8 shift steps before
// the next beat is taken. On the last byte the inverted CRC bits 30..16 give
// a 15-bit hash (zero becomes one), and a restoring divider with one 17-bit
// compare/subtract reduces it modulo bucket_count, one hash bit per cycle,
// after which the block waits in the done state for as long as the
// previous result still sits unread in the output register. bucket_count
// of zero gives bucket index 0. Write bucket_count only while idle.
module key_hash_bucket_select_core
    import khbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [BUCKET_W-1:0] i_cfg_wr_data,
    khbs_in_if.sink             i_in,
    khbs_out_if.source          o_out
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CRC_W-1:0]      r_crc, n_crc;
    logic                  r_last, n_last;
    logic [HASH_W-1:0]     r_hash, n_hash;
    logic [BUCKET_W-1:0]   r_rem, n_rem;
    logic [BUCKET_W-1:0]   r_bucket;
    logic                  r_out_valid, n_out_valid;
    logic [HASH_W-1:0]     r_out_hash;
    logic [BUCKET_W-1:0]   r_out_bucket;

    logic                  in_beat;
    logic                  out_load;
    logic [CRC_W-1:0]      crc_step;
    logic [CNT_W-1:0]      hash_idx;
    logic [BUCKET_W:0]     rem_shift;
    logic                  rem_ge;
    logic [BUCKET_W-1:0]   rem_next;

    // control outputs of the sequencer
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
        in_beat    = i_in.valid && (r_state == ST_IDLE);
        out_load   = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = ST_CRC;
                end
            end
            ST_CRC: begin
                if (r_cnt == CRC_LAST_STEP) begin
                    n_state = r_last ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (r_cnt == DIV_LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // shared crc shift/xor unit: one polynomial step
    assign crc_step = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);

    // shared restoring divider step, hash bits msb first
    assign hash_idx  = DIV_LAST_STEP - r_cnt;
    assign rem_shift = {r_rem, r_hash[hash_idx]};
    assign rem_ge    = rem_shift >= {1'b0, r_bucket};
    assign rem_next  = rem_ge ? BUCKET_W'(rem_shift - {1'b0, r_bucket})
                              : BUCKET_W'(rem_shift);

    // datapath next values
    always_comb begin
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_last      = r_last;
        n_hash      = r_hash;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_crc  = r_crc ^ {{(CRC_W-KEY_W){1'b0}}, i_in.key_byte};
                    n_last = i_in.last;
                    n_cnt  = '0;
                end
            end
            ST_CRC: begin
                n_crc = crc_step;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CRC_LAST_STEP) begin
                    n_cnt = '0;
                    if (r_last) begin
                        n_hash = hash_fold(crc_step);
                        n_rem  = '0;
                        n_crc  = CRC_INIT;
                    end
                end
            end
            ST_DIV: begin
                n_rem = rem_next;
                n_cnt = r_cnt + CNT_W'(1);
            end
            default: begin
            end
        endcase
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // control and crc registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_crc       <= CRC_INIT;
            r_bucket    <= BUCKET_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_bucket <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_hash <= n_hash;
        r_rem  <= n_rem;
        if (out_load) begin
            r_out_hash   <= r_hash;
            r_out_bucket <= (r_bucket == '0) ? '0 : r_rem;
        end
    end

    // result beat
    assign o_out.valid        = r_out_valid;
    assign o_out.hash_value   = r_out_hash;
    assign o_out.bucket_index = r_out_bucket;

    // crc is back at its initial value once a key is finished
    a_crc_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_DONE) |-> (r_crc == CRC_INIT))
        else $error("crc not reinitialized after final byte");

    // partial remainder stays below the modulus
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_bucket != '0) |-> (r_rem < r_bucket))
        else $error("partial remainder out of range");

    // a new result appears only out of the done state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside done state");

    // a presented hash is never zero
    a_hash_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_hash != '0))
        else $error("zero hash presented");

endmodule
